FILE: rtl/core/spfm_pkg.sv
// Shared types and constants for the sorted prefix first-match search core.
package spfm_pkg;

	// Code geometry fixed by the word fields
	localparam int CODE_BYTES = 5;
	localparam int CODE_W     = 8 * CODE_BYTES;
	localparam int SLOT_W     = 7;
	localparam int LEN_W      = 3;
	localparam int COUNT_W    = 8;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] entry_index;
		logic [CODE_W-1:0] entry_code;
		logic [CODE_W-1:0] prefix_text;
		logic [LEN_W-1:0]  prefix_length;
	} in_word_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] first_index;
	} out_word_t;

	// Compare status handed from one byte cell to the next
	typedef struct packed {
		logic live;  // all earlier bytes equal and nonzero
		logic lt;    // code sorts before prefix
		logic miss;  // mismatch inside the prefix length
	} chain_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/core/sorted_prefix_first_match_search_core.sv
// Top level: sorted code table in byte cells and the lower-bound prefix search control.
// Load word: written to the table at the edge that accepts it, no result.
// Query word: one probe per cycle through the byte-cell chain, at most floor(log2(n))+1 probes
//   for n entries; the result then passes through the finish state into the output register.
// The next word is taken once the result has moved to the output register.
// Reset clears control, the entry count and the output valid; table contents stay undefined.
module sorted_prefix_first_match_search_core import spfm_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [COUNT_W-1:0]   cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t              state_q, state_n;
	logic [COUNT_W-1:0]  entry_count_q;
	logic [CW-1:0]       lo_q, lo_n;
	logic [CW-1:0]       hx_q, hx_n;     // exclusive upper bound
	logic [AW-1:0]       mid_q, mid_n;
	logic [AW-1:0]       best_q, best_n;
	logic                found_q, found_n;
	logic [CODE_W-1:0]   pre_q;
	logic [LEN_W-1:0]    len_q;
	logic                out_valid_q;
	out_word_t           out_data_q;

	logic                accept;
	logic                load_wr;
	logic                out_load;
	logic [CW-1:0]       n_eff;
	logic [CW-1:0]       mid_w;
	logic [CW-1:0]       span;
	logic                hit;
	logic [LEN_W-1:0]    len_clamped;
	chain_t              chain [CODE_BYTES+1];

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign accept    = in_valid & in_ready;
	assign load_wr   = accept & (in_data.command == CMD_LOAD) &
	                   (int'(in_data.entry_index) < TABLE_DEPTH);

	// Searched entry count clamped to the table depth, prefix length clamped to the code width
	always_comb begin
		if (int'(entry_count_q) > TABLE_DEPTH) begin
			n_eff = CW'(TABLE_DEPTH);
		end else begin
			n_eff = CW'(entry_count_q);
		end
		if (int'(in_data.prefix_length) > CODE_BYTES) begin
			len_clamped = LEN_W'(CODE_BYTES);
		end else begin
			len_clamped = in_data.prefix_length;
		end
	end

	// Byte cell chain
	assign chain[0] = '{live: 1'b1, lt: 1'b0, miss: 1'b0};

	for (genvar i = 0; i < CODE_BYTES; i++) begin : g_cell
		spfm_cell #(
			.BYTE_POS    (i),
			.TABLE_DEPTH (TABLE_DEPTH)
		) u_cell (
			.clk       (clk),
			.wr_en     (load_wr),
			.wr_addr   (AW'(in_data.entry_index)),
			.wr_byte   (in_data.entry_code[8*(CODE_BYTES-1-i) +: 8]),
			.rd_addr   (mid_n),
			.pre_byte  (pre_q[8*(CODE_BYTES-1-i) +: 8]),
			.pre_len   (len_q),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign hit = ~chain[CODE_BYTES].miss;

	// Next state, search bounds and next probe address
	always_comb begin
		state_n  = state_q;
		lo_n     = lo_q;
		hx_n     = hx_q;
		best_n   = best_q;
		found_n  = found_q;
		mid_n    = mid_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		mid_w    = CW'(mid_q);
		span     = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				lo_n     = '0;
				hx_n     = n_eff;
				span     = n_eff - CW'(1);
				mid_n    = AW'(span >> 1);
				if (accept && in_data.command == CMD_QUERY) begin
					found_n = 1'b0;
					best_n  = '0;
					if (n_eff == '0) begin
						state_n = ST_FINISH;
					end else begin
						state_n = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					best_n  = mid_q;
					found_n = 1'b1;
					hx_n    = mid_w;
				end else if (chain[CODE_BYTES].lt) begin
					lo_n = mid_w + CW'(1);
				end else begin
					hx_n = mid_w;
				end
				span  = hx_n - lo_n - CW'(1);
				mid_n = AW'(lo_n + (span >> 1));
				if (lo_n >= hx_n) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			state_q <= state_n;
			found_q <= found_n;
			if (cfg_valid && cfg_ready) begin
				entry_count_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search datapath and output word
	always_ff @(posedge clk) begin
		lo_q   <= lo_n;
		hx_q   <= hx_n;
		mid_q  <= mid_n;
		best_q <= best_n;
		if (accept) begin
			pre_q <= in_data.prefix_text;
			len_q <= len_clamped;
		end
		if (out_load) begin
			out_data_q.found       <= found_q;
			out_data_q.first_index <= found_q ? SLOT_W'(best_q) : '0;
		end
	end

	// Checks
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.found || out_data.first_index == '0))
		else $error("not-found result carries a nonzero index");

	a_search_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> lo_q < hx_q)
		else $error("search running on an empty range");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> (CW'(mid_q) >= lo_q && CW'(mid_q) < hx_q))
		else $error("probe address outside the search range");

endmodule

FILE: rtl/core/spfm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module spfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/spfm_cell.sv
// Byte cell: holds one byte column of the code table and extends the compare chain.
module spfm_cell import spfm_pkg::*; #(
	parameter int BYTE_POS    = 0,
	parameter int TABLE_DEPTH = 128
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [7:0]                     wr_byte,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	input  logic [7:0]                     pre_byte,
	input  logic [LEN_W-1:0]               pre_len,
	input  chain_t                         chain_in,
	output chain_t                         chain_out
);

	localparam logic [LEN_W-1:0] POS = LEN_W'(BYTE_POS);

	logic [7:0] code_byte;
	logic       in_range;
	logic       byte_eq;

	spfm_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_DEPTH)
	) u_col (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_byte),
		.rd_addr (rd_addr),
		.rd_data (code_byte)
	);

	// Only the cell at the first differing (or shared zero) byte decides
	always_comb begin
		in_range       = POS < pre_len;
		byte_eq        = code_byte == pre_byte;
		chain_out.live = chain_in.live & byte_eq & (code_byte != 8'd0);
		chain_out.lt   = chain_in.lt | (chain_in.live & (code_byte < pre_byte));
		chain_out.miss = chain_in.miss | (chain_in.live & ~byte_eq & in_range);
	end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sorted prefix first-match search core.
module testbench import spfm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH       = 128;
	localparam int ITEM_TARGET       = 1300;
	localparam int QUERIES_PER_PHASE = 48;
	localparam int SETTLE_CYCLES     = 32;
	localparam int HOLD_CYCLES       = 150;
	localparam int IDLE_LIMIT        = 2000;
	localparam logic [CODE_W-1:0] ALL_ONES = {CODE_W{1'b1}};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_word_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [COUNT_W-1:0]   cfg_data  = '0;

	// Shadow copy of the table and the entry count
	logic [CODE_W-1:0]    code_shadow [TABLE_DEPTH];
	logic [COUNT_W-1:0]   count_shadow = '0;

	in_word_t             pending_words[$];
	out_word_t            expected_answers[$];

	int                   words_queued    = 0;
	int                   words_sent      = 0;
	int                   answers_checked = 0;
	int                   settings_done   = 0;
	int                   errors          = 0;
	int                   quiet_cycles    = 0;
	int                   send_wait       = 0;
	int                   recv_wait       = 0;
	bit                   burst_mode      = 1'b0;
	bit                   hold_done       = 1'b0;

	sorted_prefix_first_match_search_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Byte i of a code, byte 0 most significant
	function automatic logic [7:0] byte_of(logic [CODE_W-1:0] v, int i);
		return v[8*(CODE_BYTES-1-i) +: 8];
	endfunction

	// Code starts with the first len bytes of the prefix; a shared zero byte ends as a hit
	function automatic bit leads_with(logic [CODE_W-1:0] code, logic [CODE_W-1:0] pre, int len);
		for (int i = 0; i < len; i++) begin
			if (byte_of(code, i) != byte_of(pre, i))
				return 1'b0;
			if (byte_of(code, i) == 8'h00)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// Code sorts below the prefix as zero-terminated byte strings
	function automatic bit orders_below(logic [CODE_W-1:0] code, logic [CODE_W-1:0] pre);
		for (int i = 0; i < CODE_BYTES; i++) begin
			if (byte_of(code, i) != byte_of(pre, i))
				return byte_of(code, i) < byte_of(pre, i);
			if (byte_of(code, i) == 8'h00)
				return 1'b0;
		end
		return 1'b0;
	endfunction

	// Lower-bound search that keeps going left after every hit
	function automatic out_word_t lowest_prefix_slot(logic [CODE_W-1:0] pre,
		logic [LEN_W-1:0] plen);
		out_word_t ans;
		int len;
		int span;
		int lo;
		int hi;
		int mid;
		int best;
		len  = (plen > CODE_BYTES) ? CODE_BYTES : int'(plen);
		span = (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_shadow);
		lo   = 0;
		hi   = span - 1;
		best = -1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (leads_with(code_shadow[mid], pre, len)) begin
				best = mid;
				hi   = mid - 1;
			end else if (orders_below(code_shadow[mid], pre)) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		ans.found       = (best >= 0);
		ans.first_index = (best >= 0) ? best[SLOT_W-1:0] : '0;
		return ans;
	endfunction

	function automatic int draw_gap();
		return burst_mode ? 0 : int'($urandom_range(0, 14));
	endfunction

	function automatic logic [CODE_W-1:0] rand_bits40();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[CODE_W-1:0];
	endfunction

	// Well-formed code: up to five bytes from a narrow alphabet, zero padded
	function automatic logic [CODE_W-1:0] random_text(int base, int span);
		logic [CODE_W-1:0] v;
		int len;
		v   = '0;
		len = $urandom_range(0, CODE_BYTES);
		for (int i = 0; i < len; i++)
			v[8*(CODE_BYTES-1-i) +: 8] = 8'(base + $urandom_range(0, span));
		return v;
	endfunction

	function automatic logic [CODE_W-1:0] text_code(string s);
		logic [CODE_W-1:0] v;
		v = '0;
		for (int i = 0; i < CODE_BYTES && i < s.len(); i++)
			v[8*(CODE_BYTES-1-i) +: 8] = s[i];
		return v;
	endfunction

	task automatic queue_load(int slot, logic [CODE_W-1:0] code);
		in_word_t w;
		w.command       = CMD_LOAD;
		w.entry_index   = slot[SLOT_W-1:0];
		w.entry_code    = code;
		w.prefix_text   = rand_bits40();
		w.prefix_length = LEN_W'($urandom_range(0, 7));
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic queue_query(logic [CODE_W-1:0] pre, int len);
		in_word_t w;
		w.command       = CMD_QUERY;
		w.entry_index   = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
		w.entry_code    = rand_bits40();
		w.prefix_text   = pre;
		w.prefix_length = len[LEN_W-1:0];
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Block is idle: nothing queued, nothing offered, no result outstanding, then settle
	task automatic wait_drained();
		@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_entry_count(logic [COUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		count_shadow = value;
		settings_done++;
		@(negedge clk);
	endtask

	// Input driver: one word per handshake, random gap drawn after each
	always @(posedge clk) begin
		bit offering;
		offering = in_valid;
		if (!arst_n) begin
			offering  = 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				words_sent++;
				if (in_data.command == CMD_LOAD)
					code_shadow[in_data.entry_index] = in_data.entry_code;
				else
					expected_answers.push_back(
						lowest_prefix_slot(in_data.prefix_text, in_data.prefix_length));
				send_wait = draw_gap();
				offering  = 1'b0;
			end
			if (!offering) begin
				if (send_wait != 0) begin
					send_wait--;
				end else if (pending_words.size() != 0) begin
					in_data  <= pending_words.pop_front();
					offering = 1'b1;
				end
			end
		end
		in_valid <= offering;
	end

	// Result monitor with random back-pressure and one long hold-off
	always @(posedge clk) begin
		out_word_t want;
		bit        take;
		take = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_answers.size() == 0) begin
					$error("result word with nothing pending: found=%0b first_index=%0d",
						out_data.found, out_data.first_index);
					errors++;
				end else begin
					want = expected_answers.pop_front();
					if (out_data.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, out_data.found);
						errors++;
					end
					if (out_data.first_index !== want.first_index) begin
						$error("first_index: expected %0d, got %0d",
							want.first_index, out_data.first_index);
						errors++;
					end
				end
				answers_checked++;
				recv_wait = draw_gap();
				if (!hold_done && answers_checked >= 60 && pending_words.size() > 20) begin
					recv_wait = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (recv_wait != 0)
				recv_wait--;
			else
				take = 1'b1;
		end
		out_ready <= take;
	end

	// Watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin
		string              seed_words [8];
		logic [CODE_W-1:0]  codes [TABLE_DEPTH];
		logic [CODE_W-1:0]  key;
		logic [COUNT_W-1:0] count_val;
		int                 span_n;
		int                 phase;
		int                 base;
		int                 spread;
		int                 keep;
		int                 pick;
		int                 k;
		bit                 scrambled;

		seed_words = '{"A", "AB", "ABC", "ABD", "B", "BA", "BAA", "C"};
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table after reset, then a small known table
		queue_query(text_code("A"), 1);
		for (int i = 0; i < 8; i++)
			queue_load(i, text_code(seed_words[i]));
		wait_drained();
		set_entry_count(8'd8);
		queue_query(text_code(""), 0);      // zero length hits slot 0
		queue_query(text_code("AB"), 2);    // several hits, lowest wins
		queue_query(text_code("B"), 1);
		queue_query(text_code("BAA"), 3);
		queue_query(text_code("ABD"), 7);   // length clamps to the code width
		queue_query(text_code("AB"), 5);    // zero byte inside the length
		queue_query(text_code("D"), 1);     // miss past the end
		queue_query(ALL_ONES, 5);           // all-ones prefix misses
		queue_query(text_code("C"), 6);
		queue_query(text_code(""), 5);      // empty string prefix at full length
		queue_query(text_code("0"), 1);     // miss below the first entry

		// Random phases: new count, reload the searched slots, then queries
		phase = 0;
		while (words_queued < ITEM_TARGET) begin
			case (phase)
				0:       count_val = 8'd128;
				1:       count_val = 8'd1;
				2:       count_val = 8'd255;
				3:       count_val = 8'd0;
				4:       count_val = 8'd2;
				5:       count_val = 8'd129;
				default: count_val = COUNT_W'($urandom_range(0, 255));
			endcase
			span_n    = (count_val > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_val);
			scrambled = (phase % 4 == 3);
			wait_drained();
			burst_mode = (phase % 5 == 2);
			set_entry_count(count_val);

			case ($urandom_range(0, 2))
				0:       base = 8'h41;
				1:       base = 8'hFC;
				default: base = $urandom_range(1, 252);
			endcase
			spread = $urandom_range(0, 3);
			for (int i = 0; i < span_n; i++)
				codes[i] = scrambled ? rand_bits40() : random_text(base, spread);

			// Insertion sort keeps the well-formed tables ascending
			if (!scrambled) begin
				for (int i = 1; i < span_n; i++) begin
					key = codes[i];
					k   = i - 1;
					while (k >= 0 && codes[k] > key) begin
						codes[k+1] = codes[k];
						k--;
					end
					codes[k+1] = key;
				end
			end
			for (int i = 0; i < span_n; i++)
				queue_load(i, codes[i]);

			// Mostly prefixes cut from stored codes, some near misses and noise
			for (int q = 0; q < QUERIES_PER_PHASE; q++) begin
				pick = $urandom_range(0, 9);
				if (span_n == 0)
					pick = 8;
				if (pick < 5) begin
					keep = $urandom_range(0, CODE_BYTES);
					key  = codes[$urandom_range(0, span_n - 1)] &
						(ALL_ONES << (8 * (CODE_BYTES - keep)));
					queue_query(key, ($urandom_range(0, 3) == 0) ?
						int'($urandom_range(0, 7)) : keep);
				end else if (pick < 8) begin
					queue_query(random_text(base, spread), $urandom_range(0, 7));
				end else begin
					queue_query(rand_bits40(), $urandom_range(0, 7));
				end
			end
			phase++;
		end

		wait_drained();
		$display("covered %0d input words and %0d search results over %0d count settings",
			words_sent, answers_checked, settings_done);
		$display("long output hold-off %0s", hold_done ? "applied" : "not reached");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
